// File: rtl/t2i_pkg.sv
// ============================================================================
// t2i_pkg
// Shared widths, constants and the classified character word for the parser.
// ============================================================================
package t2i_pkg;

    localparam int CHAR_W   = 8;
    localparam int BASE_W   = 5;
    localparam int DIGIT_W  = 6;
    localparam int VALUE_W  = 32;
    localparam int INDEX_W  = 16;

    localparam int DEFAULT_MAX_LEN     = 65535;
    localparam int DEFAULT_QUEUE_DEPTH = 4;

    localparam logic [BASE_W-1:0] BASE_AUTO = 5'd0;
    localparam logic [BASE_W-1:0] BASE_BIN  = 5'd2;
    localparam logic [BASE_W-1:0] BASE_OCT  = 5'd8;
    localparam logic [BASE_W-1:0] BASE_DEC  = 5'd10;
    localparam logic [BASE_W-1:0] BASE_HEX  = 5'd16;

    localparam logic [VALUE_W-1:0] LIMIT_POS = 32'h7FFF_FFFF;
    localparam logic [VALUE_W-1:0] LIMIT_NEG = 32'h8000_0000;

    // letter digit offsets: 'A' - 10 and 'a' - 10
    localparam logic [CHAR_W-1:0] ALPHA_UC_OFS = 8'd55;
    localparam logic [CHAR_W-1:0] ALPHA_LC_OFS = 8'd87;

    // one character after classification
    typedef struct packed {
        logic                first;     // first character of a string
        logic                last;      // final character of a string
        logic [BASE_W-1:0]   base;      // clamped radix register at this char
        logic                is_space;
        logic                is_minus;
        logic                is_plus;
        logic                is_zero;   // the character '0'
        logic                is_x;      // 'x' or 'X'
        logic                is_b;      // 'b' or 'B'
        logic                digit_ok;  // 0-9, A-Z, a-z
        logic [DIGIT_W-1:0]  digit;     // value 0..35
    } t_word;

endpackage

// File: rtl/t2i_front.sv
// ============================================================================
// t2i_front
// Accepts characters, tracks string position, classifies each into a word.
// ============================================================================
module t2i_front #(
    parameter int MAX_STRING_LENGTH = t2i_pkg::DEFAULT_MAX_LEN
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    input  logic [t2i_pkg::BASE_W-1:0]  i_cfg_data,
    input  logic                        i_valid,
    input  logic [t2i_pkg::CHAR_W-1:0]  i_char,
    input  logic                        i_last,
    input  logic                        i_q_ready,
    output logic                        o_ready,
    output logic                        o_push,
    output t2i_pkg::t_word              o_word
);
    import t2i_pkg::*;

    localparam int POS_W = $clog2(MAX_STRING_LENGTH + 1);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_STRING_LENGTH);

    logic [BASE_W-1:0] r_number_base;
    logic [POS_W-1:0]  r_position;
    logic [POS_W-1:0]  n_position;
    logic              over_len;
    logic [CHAR_W-1:0] ch;

    assign over_len = (r_position >= POS_MAX);
    assign ch       = over_len ? '0 : i_char;   // past the length limit acts as NUL
    assign o_ready  = i_q_ready;
    assign o_push   = i_valid && i_q_ready;

    always_comb begin
        o_word          = '0;
        o_word.first    = (r_position == '0);
        o_word.last     = i_last;
        o_word.base     = (r_number_base > BASE_HEX) ? BASE_HEX : r_number_base;
        o_word.is_space = (ch == 8'h20) || (ch >= 8'h09 && ch <= 8'h0D);
        o_word.is_minus = (ch == "-");
        o_word.is_plus  = (ch == "+");
        o_word.is_zero  = (ch == "0");
        o_word.is_x     = (ch == "x") || (ch == "X");
        o_word.is_b     = (ch == "b") || (ch == "B");
        if (ch >= "0" && ch <= "9") begin
            o_word.digit_ok = 1'b1;
            o_word.digit    = DIGIT_W'(ch - "0");
        end else if (ch >= "A" && ch <= "Z") begin
            o_word.digit_ok = 1'b1;
            o_word.digit    = DIGIT_W'(ch - ALPHA_UC_OFS);
        end else if (ch >= "a" && ch <= "z") begin
            o_word.digit_ok = 1'b1;
            o_word.digit    = DIGIT_W'(ch - ALPHA_LC_OFS);
        end
    end

    always_comb begin
        n_position = r_position;
        if (o_push) begin
            if (i_last) begin
                n_position = '0;
            end else if (!over_len) begin
                n_position = r_position + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_number_base <= BASE_AUTO;
            r_position    <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_number_base <= i_cfg_data;
            end
            r_position <= n_position;
        end
    end

endmodule

// File: rtl/t2i_queue.sv
// ============================================================================
// t2i_queue
// Short register queue of classified words between front and back.
// ============================================================================
module t2i_queue #(
    parameter int DEPTH = t2i_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  t2i_pkg::t_word  i_word,
    output logic            o_ready,
    input  logic            i_pop,
    output logic            o_valid,
    output t2i_pkg::t_word  o_word
);
    import t2i_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_word            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_ready = (r_count != CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_word  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: rtl/t2i_back.sv
// ============================================================================
// t2i_back
// Parse engine: phase sequencing, digit accumulate with overflow stop, result.
// ============================================================================
module t2i_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_q_valid,
    input  t2i_pkg::t_word               i_word,
    output logic                         o_pop,
    output logic                         o_m_valid,
    input  logic                         i_m_ready,
    output logic [t2i_pkg::VALUE_W-1:0]  o_value,
    output logic [t2i_pkg::INDEX_W-1:0]  o_end_index
);
    import t2i_pkg::*;

    typedef enum logic [2:0] {
        PH_SPACE,
        PH_LEAD,
        PH_ZERO,
        PH_DIGITS,
        PH_DONE
    } t_phase;

    localparam int PROD_W = VALUE_W + BASE_W + 1;

    t_phase             r_phase;
    logic               r_minus;
    logic [VALUE_W-1:0] r_mag;
    logic [BASE_W-1:0]  r_abase;
    logic [INDEX_W-1:0] r_cons;

    t_phase             n_phase;
    logic               n_minus;
    logic [VALUE_W-1:0] n_mag;
    logic [BASE_W-1:0]  n_abase;
    logic [INDEX_W-1:0] n_cons;
    logic [INDEX_W-1:0] fin_cons;

    logic               out_free;
    logic               step;
    logic               pend;
    logic               dig_try;
    logic [BASE_W-1:0]  radix;
    logic [PROD_W-1:0]  prod;
    logic [VALUE_W-1:0] limit;
    logic               dig_fits;

    assign out_free = !o_m_valid || i_m_ready;
    assign step     = i_q_valid && (!i_word.last || out_free);
    assign o_pop    = step;

    always_comb begin
        n_phase = r_phase;
        n_minus = r_minus;
        n_mag   = r_mag;
        n_abase = i_word.first ? i_word.base : r_abase;
        n_cons  = r_cons;
        pend    = 1'b1;
        dig_try = 1'b0;

        if (n_phase == PH_SPACE) begin
            priority if (i_word.is_space) begin
                n_cons = n_cons + 1'b1;
                pend   = 1'b0;
            end else if (i_word.is_minus) begin
                n_minus = 1'b1;
                n_cons  = n_cons + 1'b1;
                n_phase = PH_LEAD;
                pend    = 1'b0;
            end else if (i_word.is_plus) begin
                n_cons  = n_cons + 1'b1;
                n_phase = PH_LEAD;
                pend    = 1'b0;
            end else begin
                n_phase = PH_LEAD;
            end
        end

        if (pend && n_phase == PH_LEAD) begin
            if (i_word.is_zero && (n_abase == BASE_AUTO || n_abase == BASE_BIN ||
                                   n_abase == BASE_HEX)) begin
                n_phase = PH_ZERO;      // hold the zero, prefix may follow
                pend    = 1'b0;
            end else begin
                if (n_abase == BASE_AUTO) n_abase = BASE_DEC;
                n_phase = PH_DIGITS;
            end
        end

        if (pend && n_phase == PH_ZERO) begin
            priority if ((n_abase == BASE_HEX || n_abase == BASE_AUTO) && i_word.is_x) begin
                n_cons  = n_cons + 16'd2;
                n_abase = BASE_HEX;
                n_phase = PH_DIGITS;
                pend    = 1'b0;
            end else if ((n_abase == BASE_BIN || n_abase == BASE_AUTO) && i_word.is_b) begin
                n_cons  = n_cons + 16'd2;
                n_abase = BASE_BIN;
                n_phase = PH_DIGITS;
                pend    = 1'b0;
            end else begin
                // held zero becomes a digit; magnitude is still zero
                if (n_abase == BASE_AUTO) n_abase = BASE_OCT;
                n_cons  = n_cons + 1'b1;
                n_phase = PH_DIGITS;
            end
        end

        if (pend && n_phase == PH_DIGITS) begin
            dig_try = 1'b1;
        end

        radix    = (n_abase == BASE_AUTO) ? BASE_DEC : n_abase;
        limit    = n_minus ? LIMIT_NEG : LIMIT_POS;
        prod     = PROD_W'(n_mag) * PROD_W'(radix) + PROD_W'(i_word.digit);
        dig_fits = i_word.digit_ok && (BASE_W'(i_word.digit) < radix) &&
                   (i_word.digit < DIGIT_W'(radix)) && (prod <= PROD_W'(limit));

        if (dig_try) begin
            if (dig_fits) begin
                n_mag  = prod[VALUE_W-1:0];
                n_cons = n_cons + 1'b1;
            end else begin
                n_phase = PH_DONE;
            end
        end

        // string ends on a held zero: it counts as the digit
        fin_cons = (n_phase == PH_ZERO) ? n_cons + 1'b1 : n_cons;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_SPACE;
            r_minus   <= 1'b0;
            r_mag     <= '0;
            r_abase   <= BASE_AUTO;
            r_cons    <= '0;
            o_m_valid <= 1'b0;
        end else begin
            if (o_m_valid && i_m_ready) begin
                o_m_valid <= 1'b0;
            end
            if (step) begin
                if (i_word.last) begin
                    o_m_valid   <= 1'b1;
                    o_value     <= n_minus ? (~n_mag + 1'b1) : n_mag;
                    o_end_index <= fin_cons;
                    r_phase     <= PH_SPACE;
                    r_minus     <= 1'b0;
                    r_mag       <= '0;
                    r_abase     <= BASE_AUTO;
                    r_cons      <= '0;
                end else begin
                    r_phase <= n_phase;
                    r_minus <= n_minus;
                    r_mag   <= n_mag;
                    r_abase <= n_abase;
                    r_cons  <= n_cons;
                end
            end
        end
    end

endmodule

// File: rtl/text_to_integer_parser.sv
// ============================================================================
// text_to_integer_parser
// Streaming string-to-long parser, 32-bit signed result per string.
// ============================================================================
// Usage:
//   s_axis carries one character per word (tdata[7:0]); tlast marks the
//   final character of a string. m_axis returns one word per string:
//   tdata[31:0] = signed value, tdata[47:32] = characters consumed.
//   The cfg channel writes the radix register (0 = auto, 1..16, above 16
//   acts as 16); it is sampled at the first character of each string and
//   should only be written while the block is idle. cfg is always ready.
// Throughput: one character per cycle, set by the back end's multiply-add
//   and limit compare per digit, while the queue has room and no last
//   character waits on the output register.
// Result path: the accepted tlast word goes through the queue register, then
//   the output register, behind every word still ahead of it in the queue.
// Reset clears the radix to auto, empties the queue and drops any partial
//   string; no result is pending after reset.
// Receiver stall: the back end keeps eating non-last characters; a last
//   character waits in the queue until the output register frees, and
//   s_axis_tready drops once the queue holds QUEUE_DEPTH words.
// ============================================================================
module text_to_integer_parser #(
    parameter int MAX_STRING_LENGTH = t2i_pkg::DEFAULT_MAX_LEN,
    parameter int QUEUE_DEPTH       = t2i_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // radix register write
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [t2i_pkg::BASE_W-1:0]  i_cfg_data,
    // character stream
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [7:0]                  s_axis_tdata,   // [7:0] character
    input  logic                        s_axis_tlast,   // last character
    // result stream
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [47:0]                 m_axis_tdata    // [31:0] value, [47:32] end_index
);
    import t2i_pkg::*;

    t_word front_word;
    t_word queue_word;
    logic  front_push;
    logic  queue_ready;
    logic  queue_valid;
    logic  back_pop;

    logic [VALUE_W-1:0] res_value;
    logic [INDEX_W-1:0] res_end;

    assign o_cfg_ready  = 1'b1;
    assign m_axis_tdata = {res_end, res_value};

    // front: position tracking and character classification
    t2i_front #(
        .MAX_STRING_LENGTH (MAX_STRING_LENGTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (s_axis_tvalid),
        .i_char      (s_axis_tdata[CHAR_W-1:0]),
        .i_last      (s_axis_tlast),
        .i_q_ready   (queue_ready),
        .o_ready     (s_axis_tready),
        .o_push      (front_push),
        .o_word      (front_word)
    );

    // decoupling queue
    t2i_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_word  (front_word),
        .o_ready (queue_ready),
        .i_pop   (back_pop),
        .o_valid (queue_valid),
        .o_word  (queue_word)
    );

    // back: parse engine and output register
    t2i_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (queue_valid),
        .i_word      (queue_word),
        .o_pop       (back_pop),
        .o_m_valid   (m_axis_tvalid),
        .i_m_ready   (m_axis_tready),
        .o_value     (res_value),
        .o_end_index (res_end)
    );

endmodule

// File: rtl/t2i_checker.sv
// ============================================================================
// t2i_checker
// Port-level checks on the parser: reset, stall hold, result bookkeeping.
// ============================================================================
module t2i_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata
);
    // strings accepted but not yet answered
    logic [7:0] r_open;
    logic       in_last;
    logic       out_take;

    assign in_last  = s_axis_tvalid && s_axis_tready && s_axis_tlast;
    assign out_take = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= '0;
        end else begin
            r_open <= r_open + {7'd0, in_last} - {7'd0, out_take};
        end
    end

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> r_open != 8'd0)
        else $error("result without a finished string");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[47:32] == 16'd0 |-> m_axis_tdata[31:0] == 32'd0)
        else $error("nonzero value with nothing consumed");

endmodule

bind text_to_integer_parser t2i_checker u_t2i_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
